[sv/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes and default sizes shared by the transposition table files.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Default geometry; SLOTS is a power of two
    localparam int SLOTS_DEF  = 4096;
    localparam int TABLES_DEF = 2;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 6;
    localparam int SCORE_W = 32;
    localparam int BOUND_W = 2;

    // Word kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_STORE  = 1'b1;

    // Bound codes held in each slot
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;
    localparam logic [BOUND_W-1:0] BOUND_EMPTY = 2'd3;

    // One slot of the table
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
    } t_entry;

    // Request word held while its slot is read
    typedef struct packed {
        logic                      kind;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
    } t_req;

    // Outcome of checking a request against its slot
    typedef struct packed {
        logic                      hit;
        logic                      written;
        logic signed [SCORE_W-1:0] found_score;
    } t_verdict;

endpackage

[sv/stt_eval.sv]
// ----------------------------------------------------------------------------
// stt_eval
// Decides hit or replacement for one request against the slot read for it.
// ----------------------------------------------------------------------------
module stt_eval (
    input  stt_pkg::t_req     i_req,
    input  stt_pkg::t_entry   i_entry,
    output stt_pkg::t_verdict o_verdict
);
    import stt_pkg::*;

    logic w_occupied;
    logic w_usable;
    logic w_hit;
    logic w_replace;

    assign w_occupied = (i_entry.bound != BOUND_EMPTY);

    // Bound must be usable for the window: exact, upper at or below alpha,
    // lower at or above beta
    always_comb begin
        case (i_entry.bound)
            BOUND_EXACT: w_usable = 1'b1;
            BOUND_UPPER: w_usable = ($signed(i_entry.score) <= $signed(i_req.alpha));
            BOUND_LOWER: w_usable = ($signed(i_entry.score) >= $signed(i_req.beta));
            default:     w_usable = 1'b0;
        endcase
    end

    assign w_hit = (i_req.kind == KIND_LOOKUP) && w_occupied
                   && (i_entry.depth >= i_req.depth)
                   && (i_entry.key == i_req.key) && w_usable;

    // Depth-preferred: take an empty slot or a strictly shallower entry
    assign w_replace = (i_req.kind == KIND_STORE) && (i_req.bound != BOUND_EMPTY)
                       && (!w_occupied || (i_entry.depth < i_req.depth));

    assign o_verdict.hit         = w_hit;
    assign o_verdict.written     = w_replace;
    assign o_verdict.found_score = w_hit ? i_entry.score : '0;

endmodule

[sv/search_transposition_table.sv]
// Result: a word's slot is read at the edge that takes it; the slot is then
//   checked, written back and its result registered once the output can take it.
// Words: taken one at a time, as set by the read-then-write of one slot in the
//   single table memory; a stalled result holds the second step.
// Reset: synchronous, active low; a clearing pass then marks every slot empty,
//   one slot a cycle, SLOTS*TABLES slots (8192 by default); o_in_ready low.
// ----------------------------------------------------------------------------
// search_transposition_table
// Depth-preferred, direct-mapped transposition table for game-tree search.
// ----------------------------------------------------------------------------
module search_transposition_table #(
    parameter int SLOTS  = stt_pkg::SLOTS_DEF,   // power of two
    parameter int TABLES = stt_pkg::TABLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic                              i_table_sel,
    input  logic [stt_pkg::KEY_W-1:0]         i_key,
    input  logic [stt_pkg::DEPTH_W-1:0]       i_search_depth,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_alpha,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_beta,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_score,
    input  logic [stt_pkg::BOUND_W-1:0]       i_bound_kind,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic signed [stt_pkg::SCORE_W-1:0] o_found_score,
    output logic                              o_written
);
    import stt_pkg::*;

    localparam int DEPTH  = SLOTS * TABLES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);

    // Sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;   // sweep every slot to empty
    localparam logic [1:0] ST_IDLE  = 2'd1;   // take a word, issue its read
    localparam logic [1:0] ST_EVAL  = 2'd2;   // check slot, write back, post result

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    t_req              r_req;
    t_entry            r_rd_entry;

    logic              r_out_valid;
    logic              r_hit;
    logic signed [SCORE_W-1:0] r_found_score;
    logic              r_written;

    t_entry            mem [DEPTH];

    logic              w_accept;
    logic              w_finish;
    logic              w_clr_last;
    logic              w_tbl;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    t_entry            w_mem_wdata;
    t_entry            w_new_entry;
    t_verdict          w_verdict;

    // Table select wraps modulo TABLES; a single table ignores it
    assign w_tbl     = (TABLES > 1) ? i_table_sel : 1'b0;
    assign w_rd_addr = (ADDR_W'(w_tbl) << SLOT_W) | ADDR_W'(i_key[SLOT_W-1:0]);

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // Finish only when the output register is free or being emptied
    assign w_finish   = (r_state == ST_EVAL) && (!r_out_valid || i_out_ready);
    assign w_clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (w_clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (w_accept)   n_state = ST_EVAL;
            ST_EVAL:  if (w_finish)   n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the sweep pointer while clearing
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // hold the result until the consumer takes it
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request word alongside its slot read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr      <= w_rd_addr;
            r_req.kind  <= i_kind;
            r_req.key   <= i_key;
            r_req.depth <= i_search_depth;
            r_req.alpha <= i_alpha;
            r_req.beta  <= i_beta;
            r_req.score <= i_score;
            r_req.bound <= i_bound_kind;
        end
    end

    stt_eval u_eval (
        .i_req     (r_req),
        .i_entry   (r_rd_entry),
        .o_verdict (w_verdict)
    );

    assign w_new_entry.key   = r_req.key;
    assign w_new_entry.depth = r_req.depth;
    assign w_new_entry.score = r_req.score;
    assign w_new_entry.bound = r_req.bound;

    // Write port: clearing sweep, else write back a replaced slot.
    // Reads and write-backs never share an edge, so no forwarding is needed.
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_mem_we          = i_rst_n;
            w_mem_waddr       = r_clr_addr;
            w_mem_wdata.key   = '0;
            w_mem_wdata.depth = '0;
            w_mem_wdata.score = '0;
            w_mem_wdata.bound = BOUND_EMPTY;
        end else begin
            w_mem_we    = i_rst_n && w_finish && w_verdict.written;
            w_mem_waddr = r_addr;
            w_mem_wdata = w_new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_accept) begin
            r_rd_entry <= mem[w_rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_hit         <= w_verdict.hit;
            r_found_score <= w_verdict.found_score;
            r_written     <= w_verdict.written;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_found_score = r_found_score;
    assign o_written     = r_written;

endmodule

[sv/stt_checker.sv]
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the transposition table, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_hit,
    input logic signed [stt_pkg::SCORE_W-1:0] o_found_score,
    input logic                               o_written
);
    import stt_pkg::*;

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pending;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Words taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(w_in_acc) - 2'(w_out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_hit) && $stable(o_found_score) && $stable(o_written))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 2'd0)
        else $error("result with no word outstanding");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("too many words in flight");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_written) && (o_hit || o_found_score == '0))
        else $error("inconsistent result fields");

endmodule

bind search_transposition_table stt_checker u_stt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_hit         (o_hit),
    .o_found_score (o_found_score),
    .o_written     (o_written)
);

[tb/tb_search_transposition_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_search_transposition_table
// Self-checking bench for the depth-preferred transposition table. A queue of
// lookup and store words is driven in random bursts. A behavioural copy of
// both tables predicts each result when its word is taken. Results are
// checked in order while the result channel stalls in shifting patterns.
// ----------------------------------------------------------------------------
module tb_search_transposition_table;
    import stt_pkg::*;

    localparam int N_SLOTS        = SLOTS_DEF;
    localparam int N_TABLES       = TABLES_DEF;
    localparam int N_ENTRIES      = N_SLOTS * N_TABLES;
    localparam int RANDOM_WORDS   = 1200;
    localparam int POOL_SIZE      = 16;
    // Covers the clearing pass after reset with a wide margin
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    // One request word as the bench holds it
    typedef struct packed {
        logic                      kind;
        logic                      tsel;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
    } t_probe;

    // One result word
    typedef struct packed {
        logic                      hit;
        logic signed [SCORE_W-1:0] found_score;
        logic                      written;
    } t_outcome;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_hit;
    logic signed [SCORE_W-1:0] o_found_score;
    logic                      o_written;

    // Word currently presented on the request channel
    t_probe drv_word = '0;

    // Shadow copy of both tables
    logic [KEY_W-1:0]          shadow_key   [N_ENTRIES];
    logic [DEPTH_W-1:0]        shadow_depth [N_ENTRIES];
    logic signed [SCORE_W-1:0] shadow_score [N_ENTRIES];
    logic [BOUND_W-1:0]        shadow_bound [N_ENTRIES];

    t_probe   pending_words[$];
    t_outcome expected_outcomes[$];
    bit       mismatch_seen = 1'b0;

    // Driver burst state and receiver stall state
    int burst_left = 0;
    int gap_left   = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    bit toggle_ph  = 1'b0;
    int idle_cycles = 0;

    search_transposition_table #(
        .SLOTS  (N_SLOTS),
        .TABLES (N_TABLES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (drv_word.kind),
        .i_table_sel    (drv_word.tsel),
        .i_key          (drv_word.key),
        .i_search_depth (drv_word.depth),
        .i_alpha        (drv_word.alpha),
        .i_beta         (drv_word.beta),
        .i_score        (drv_word.score),
        .i_bound_kind   (drv_word.bound),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_found_score  (o_found_score),
        .o_written      (o_written)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_probe make_word(input logic kind, input logic tsel,
                                         input logic [KEY_W-1:0] key,
                                         input int depth,
                                         input logic signed [SCORE_W-1:0] alpha,
                                         input logic signed [SCORE_W-1:0] beta,
                                         input logic signed [SCORE_W-1:0] score,
                                         input logic [BOUND_W-1:0] bound);
        t_probe w;
        w.kind  = kind;
        w.tsel  = tsel;
        w.key   = key;
        w.depth = DEPTH_W'(depth);
        w.alpha = alpha;
        w.beta  = beta;
        w.score = score;
        w.bound = bound;
        return w;
    endfunction

    // Work out the result of one taken word and update the shadow tables.
    // The slot is the low key bits within the selected table.
    function automatic t_outcome apply_probe(input t_probe w);
        int       idx;
        logic     usable;
        t_outcome r;
        r   = '0;
        idx = (int'(w.tsel) % N_TABLES) * N_SLOTS + int'(w.key % 64'(N_SLOTS));
        if (w.kind == KIND_LOOKUP) begin
            if (shadow_bound[idx] != BOUND_EMPTY && shadow_depth[idx] >= w.depth &&
                shadow_key[idx] == w.key) begin
                // upper bound usable at or below alpha, lower at or above beta
                usable = (shadow_bound[idx] == BOUND_EXACT) ||
                         (shadow_bound[idx] == BOUND_UPPER && shadow_score[idx] <= w.alpha) ||
                         (shadow_bound[idx] == BOUND_LOWER && shadow_score[idx] >= w.beta);
                if (usable) begin
                    r.hit         = 1'b1;
                    r.found_score = shadow_score[idx];
                end
            end
        end else if (w.bound != BOUND_EMPTY) begin
            // replace an empty slot or a strictly shallower one
            if (shadow_bound[idx] == BOUND_EMPTY || shadow_depth[idx] < w.depth) begin
                shadow_key[idx]   = w.key;
                shadow_depth[idx] = w.depth;
                shadow_score[idx] = w.score;
                shadow_bound[idx] = w.bound;
                r.written         = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of words with random gaps between them.
    // Hold the word and valid until taken; predict at the taking edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_outcomes.push_back(apply_probe(drv_word));
            end
            // Advance only once the channel is free
            if (!i_in_valid || o_in_ready) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                              : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    drv_word   <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    burst_left = burst_left - 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: the ready pattern switches at random between four modes
    // (always ready, alternating, random, mostly stalled).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            mode_left = 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 64);
            end
            mode_left = mode_left - 1;
            toggle_ph = !toggle_ph;
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= toggle_ph;
                2:       i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result word: hit %0b found_score %0d written %0b",
                         $realtime, o_hit, o_found_score, o_written);
                mismatch_seen = 1'b1;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit mismatch: expected %0b actual %0b",
                             $realtime, want.hit, o_hit);
                    mismatch_seen = 1'b1;
                end
                if (o_found_score !== want.found_score) begin
                    $display("%0t: found_score mismatch: expected %0d actual %0d",
                             $realtime, want.found_score, o_found_score);
                    mismatch_seen = 1'b1;
                end
                if (o_written !== want.written) begin
                    $display("%0t: written mismatch: expected %0b actual %0b",
                             $realtime, want.written, o_written);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no word taken either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0]          pool_key   [POOL_SIZE];
        logic                      pool_tsel  [POOL_SIZE];
        int                        pool_depth [POOL_SIZE];
        logic signed [SCORE_W-1:0] pool_score [POOL_SIZE];
        logic [KEY_W-1:0]          k_ones;
        logic [KEY_W-1:0]          k_far;
        logic [KEY_W-1:0]          k_fives;
        logic signed [SCORE_W-1:0] s;
        logic [BOUND_W-1:0]        b;
        int                        p;
        int                        d;
        int                        roll;

        for (int i = 0; i < N_ENTRIES; i++) begin
            shadow_key[i]   = '0;
            shadow_depth[i] = '0;
            shadow_score[i] = '0;
            shadow_bound[i] = BOUND_EMPTY;
        end

        k_ones  = '1;
        k_far   = 64'h0000_0001_0000_1000;   // same slot as key zero
        k_fives = 64'h5555_5555_5555_5555;

        // Directed words: empty slots, equal depth, ignored bound code,
        // key mismatch in a shared slot, window edges of both bound kinds
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, '0, 0, '0, '0, '0, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_STORE, 1'b0, '0, 0, '0, '0, SCORE_MAX,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_STORE, 1'b0, '0, 0, '0, '0, 5, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, '0, 0, '0, '0, '0, BOUND_EMPTY));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, '0, 1, '0, '0, '0, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b1, '0, 0, '0, '0, '0, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_STORE, 1'b0, '0, 9, '0, '0, 77, BOUND_EMPTY));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, '0, 1, '0, '0, '0, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_STORE, 1'b1, k_ones, 63, SCORE_MIN, SCORE_MAX,
                                          -5, BOUND_UPPER));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b1, k_ones, 63, -5, SCORE_MAX, '0,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b1, k_ones, 63, -6, SCORE_MAX, '0,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b1, k_ones, 0, SCORE_MAX, SCORE_MIN,
                                          '0, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_STORE, 1'b1, 64'hFFFF_0000_0000_0FFF, 63, '0,
                                          '0, 1, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b1, k_ones, 63, SCORE_MIN, '0, '0,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_STORE, 1'b0, k_far, 10, '0, '0, SCORE_MIN,
                                          BOUND_LOWER));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, '0, 0, '0, '0, '0, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, k_far, 10, '0, SCORE_MIN, '0,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, k_far, 10, '0, SCORE_MIN + 1,
                                          '0, BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, k_far, 11, '0, SCORE_MIN, '0,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_STORE, 1'b0, k_far, 11, '0, '0, '0,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b0, k_far, 0, SCORE_MIN, SCORE_MAX,
                                          SCORE_MAX, BOUND_EMPTY));
        pending_words.push_back(make_word(KIND_STORE, 1'b1, k_fives, 32, '0, '0,
                                          32'sh5555_5555, BOUND_LOWER));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b1, k_fives, 32, '0, '0, '0,
                                          BOUND_EXACT));
        pending_words.push_back(make_word(KIND_LOOKUP, 1'b1, ~k_fives, 0, '0, '0, '0,
                                          BOUND_EXACT));

        // Key pool for store-then-probe traffic. The last four entries share
        // a table and slot with the first four but differ in the high bits.
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < POOL_SIZE - 4) begin
                pool_tsel[i] = i[0];
                pool_key[i]  = {$urandom, $urandom};
                pool_key[i][11:0] = 12'(i * 331 + 7);
            end else begin
                pool_tsel[i] = pool_tsel[i - (POOL_SIZE - 4)];
                pool_key[i]  = {$urandom, $urandom};
                pool_key[i][11:0] = pool_key[i - (POOL_SIZE - 4)][11:0];
            end
            pool_depth[i] = -1;
            pool_score[i] = '0;
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                // noise: every field at random
                pending_words.push_back(make_word(1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1)),
                                                  {$urandom, $urandom}, $urandom_range(0, 63),
                                                  $urandom, $urandom, $urandom,
                                                  BOUND_W'($urandom_range(0, 3))));
            end else begin
                p = $urandom_range(0, POOL_SIZE - 1);
                if (roll < 50) begin
                    // store, mostly deeper than the last one for this key
                    if ($urandom_range(0, 9) == 0) begin
                        d = $urandom_range(0, 63);
                    end else begin
                        d = pool_depth[p] + $urandom_range(0, 2);
                        if (d < 0) d = 0;
                        if (d > 63) d = 63;
                    end
                    s = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : int'($urandom_range(0, 400)) - 200;
                    b = ($urandom_range(0, 19) == 0) ? BOUND_EMPTY
                                                     : BOUND_W'($urandom_range(0, 2));
                    pending_words.push_back(make_word(KIND_STORE, pool_tsel[p], pool_key[p], d,
                                                      $urandom, $urandom, s, b));
                    if (b != BOUND_EMPTY && d > pool_depth[p]) begin
                        pool_depth[p] = d;
                        pool_score[p] = s;
                    end
                end else begin
                    // lookup, mostly within the stored depth and near its score
                    if ($urandom_range(0, 6) == 0 || pool_depth[p] < 0) begin
                        d = $urandom_range(0, 63);
                    end else begin
                        d = $urandom_range(0, pool_depth[p]);
                    end
                    pending_words.push_back(make_word(KIND_LOOKUP, pool_tsel[p], pool_key[p], d,
                                                      pool_score[p] + int'($urandom_range(0, 4))
                                                          - 2,
                                                      pool_score[p] + int'($urandom_range(0, 4))
                                                          - 2,
                                                      $urandom,
                                                      BOUND_W'($urandom_range(0, 3))));
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every word taken, every result back, then a short settle
        do begin
            @(posedge i_clk);
        end while (pending_words.size() != 0 || i_in_valid || expected_outcomes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_outcomes.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, expected_outcomes.size());
            mismatch_seen = 1'b1;
        end
        if (!mismatch_seen) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
